// File: rtl/core/lz2f_pkg.sv
// Shared types, codes and constants of the two-bit-flag LZ decompressor.
package lz2f_pkg;

    // Parser phases, one-hot
    typedef enum logic [10:0] {
        PH_FLAG   = 11'b000_0000_0001,
        PH_LIT    = 11'b000_0000_0010,
        PH_RUNLEN = 11'b000_0000_0100,
        PH_SM_HI  = 11'b000_0000_1000,
        PH_SM_LO  = 11'b000_0001_0000,
        PH_SUB    = 11'b000_0010_0000,
        PH_LL_LO  = 11'b000_0100_0000,
        PH_LM_HI  = 11'b000_1000_0000,
        PH_LM_LO  = 11'b001_0000_0000,
        PH_SKIP   = 11'b010_0000_0000,
        PH_COPY   = 11'b100_0000_0000
    } phase_t;

    // Error codes on the result
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_ORDER = 2'd1,
        ERR_DIST  = 2'd2
    } err_t;

    // Flag-byte code values
    localparam logic [1:0] CODE_LIT   = 2'd0;
    localparam logic [1:0] CODE_RUN   = 2'd1;
    localparam logic [1:0] CODE_MATCH = 2'd2;

    // Sub-mode selector values
    localparam logic [1:0] SUB_LONG_LIT   = 2'd0;
    localparam logic [1:0] SUB_LONG_MATCH = 2'd1;
    localparam logic [1:0] SUB_NOP        = 2'd2;

    localparam int DIST_W  = 11;
    localparam int COUNT_W = 15;

    localparam logic [COUNT_W-1:0] RUN_BIAS      = 15'h0002;
    localparam logic [COUNT_W-1:0] SM_LEN_BIAS   = 15'h0004;
    localparam logic [COUNT_W-1:0] LL_BIAS       = 15'h0102;
    localparam logic [COUNT_W-1:0] LM_LEN_BIAS   = 15'h0024;
    localparam logic [2:0]         GROUP_SLOTS   = 3'd4;

    // Phase that a fresh 2-bit code opens
    function automatic phase_t code_phase(input logic [1:0] code);
        phase_t ph;
        case (code)
            CODE_LIT:   ph = PH_LIT;
            CODE_RUN:   ph = PH_RUNLEN;
            CODE_MATCH: ph = PH_SM_HI;
            default:    ph = PH_SUB;
        endcase
        return ph;
    endfunction

endpackage

// File: rtl/core/lz_two_bit_flag_decompressor_unit.sv
// Two-bit-flag LZ decompressor: parser, history memory and output stage.
// Path: an accepted item passes through the stage-1 register and then the output register to the master side.
// Throughput: one item (compressed byte or match tick) per cycle while m_axis_tready holds; the parser updates
//   its state in the accept cycle, history is read at accept and written back from stage 1, forwarded.
// Reset (rst_n, asynchronous): parser expects a flag byte, counters, pointer and stream length
//   cleared; history RAM contents are not cleared.
module lz_two_bit_flag_decompressor_unit #(
    parameter int WINDOW_DEPTH = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: stream length in output bytes
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic [0:0]  s_axis_tuser,   // [0] mode (1 = match tick)
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] copy_pending, [15:9] zero
    output logic [2:0]  m_axis_tuser,   // [0] out_valid, [2:1] error
    output logic        m_axis_tlast    // last
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int DW = lz2f_pkg::DIST_W;
    localparam int CW = lz2f_pkg::COUNT_W;

    // ---------------------------------------------------------------
    // Parser state
    // ---------------------------------------------------------------
    lz2f_pkg::phase_t phase_reg, phase_next;
    logic [7:0]    flags_reg, flags_next;
    logic [2:0]    slot_reg, slot_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dist_reg, dist_next;
    logic [5:0]    partial_reg, partial_next;
    logic [31:0]   produced_reg, produced_next;
    logic [31:0]   orig_len_reg;
    logic [AW-1:0] hp_reg, hp_next;

    // ---------------------------------------------------------------
    // Stage 1: the accepted item, waiting for history read data
    // ---------------------------------------------------------------
    logic          s1_valid_reg;
    logic          s1_emit_reg;      // item produces a byte
    logic          s1_from_mem_reg;  // byte comes from history
    logic          s1_fwd_reg;       // history byte is the one written just before
    logic [7:0]    s1_lit_reg;
    logic [AW-1:0] s1_waddr_reg;
    logic          s1_last_reg;
    logic          s1_pend_reg;
    lz2f_pkg::err_t s1_err_reg;
    logic [7:0]    fwd_byte_reg;

    // Output register
    logic          out_valid_reg;
    logic          out_emit_reg;
    logic [7:0]    out_byte_reg;
    logic          out_pend_reg;
    logic          out_last_reg;
    lz2f_pkg::err_t out_err_reg;

    // History RAM
    logic [7:0]    hist_mem [WINDOW_DEPTH];
    logic [7:0]    hist_rdata_reg;

    logic          accept;
    logic          s1_adv;
    logic [7:0]    s1_byte;
    logic [AW-1:0] raddr;
    logic [AW:0]   back_span;
    logic [AW:0]   raddr_diff;
    logic          mode;
    logic [7:0]    b;

    // per-item decode results
    logic          done;
    logic          emit;
    logic          from_mem;
    logic          adv_code;
    logic          close_group;
    logic          last;
    logic          pend;
    lz2f_pkg::err_t err;
    logic [31:0]   produced_inc;
    logic [DW-1:0] dist_lo;
    logic [31:0]   dist_span;
    logic [2:0]    slot_inc;
    logic [7:0]    flags_shift;

    assign mode = s_axis_tuser[0];
    assign b    = s_axis_tdata;

    // Advance stage 1 when the output register is free or being drained
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Source of the next match byte: distance+1 behind the write pointer, modulo the window
    assign back_span  = (AW+1)'(dist_reg) + (AW+1)'(1);
    assign raddr_diff = {1'b0, hp_reg} - back_span;
    assign raddr      = raddr_diff[AW] ? AW'(raddr_diff + (AW+1)'(WINDOW_DEPTH)) :
                                         raddr_diff[AW-1:0];

    assign produced_inc = produced_reg + 32'd1;
    assign dist_lo      = dist_reg | DW'(b[7:5]);
    assign dist_span    = 32'(dist_lo) + 32'd1;
    assign slot_inc     = slot_reg + 3'd1;
    assign flags_shift  = {2'b00, flags_reg[7:2]};

    // ---------------------------------------------------------------
    // Parser: next state for one accepted item
    // ---------------------------------------------------------------
    always_comb
    begin
        phase_next    = phase_reg;
        flags_next    = flags_reg;
        slot_next     = slot_reg;
        rem_next      = rem_reg;
        dist_next     = dist_reg;
        partial_next  = partial_reg;
        produced_next = produced_reg;
        hp_next       = hp_reg;
        emit          = 1'b0;
        from_mem      = 1'b0;
        adv_code      = 1'b0;
        close_group   = 1'b0;
        err           = lz2f_pkg::ERR_NONE;
        done          = produced_reg >= orig_len_reg;

        if (done) begin
            err = lz2f_pkg::ERR_ORDER;
        end else if (mode) begin
            // match tick
            if (phase_reg != lz2f_pkg::PH_COPY) begin
                err = lz2f_pkg::ERR_ORDER;
            end else begin
                emit     = 1'b1;
                from_mem = 1'b1;
                rem_next = rem_reg - CW'(1);
                if (rem_reg == CW'(1)) begin
                    adv_code = 1'b1;
                end
            end
        end else begin
            case (phase_reg)
                lz2f_pkg::PH_FLAG:
                begin
                    flags_next = b;
                    slot_next  = 3'd0;
                    phase_next = lz2f_pkg::code_phase(b[1:0]);
                    if (b[1:0] == lz2f_pkg::CODE_LIT) begin
                        rem_next = CW'(1);
                    end
                end
                lz2f_pkg::PH_LIT:
                begin
                    emit     = 1'b1;
                    rem_next = rem_reg - CW'(1);
                    if (rem_reg == CW'(1)) begin
                        adv_code = 1'b1;
                    end
                end
                lz2f_pkg::PH_RUNLEN:
                begin
                    rem_next   = CW'(b) + lz2f_pkg::RUN_BIAS;
                    phase_next = lz2f_pkg::PH_LIT;
                end
                lz2f_pkg::PH_SM_HI, lz2f_pkg::PH_LM_HI:
                begin
                    dist_next  = {b, 3'b000};
                    phase_next = (phase_reg == lz2f_pkg::PH_SM_HI) ?
                                 lz2f_pkg::PH_SM_LO : lz2f_pkg::PH_LM_LO;
                end
                lz2f_pkg::PH_SM_LO, lz2f_pkg::PH_LM_LO:
                begin
                    dist_next = dist_lo;
                    if (dist_span > produced_reg) begin
                        // reaches before this stream's data: drop the match
                        err      = lz2f_pkg::ERR_DIST;
                        rem_next = '0;
                        adv_code = 1'b1;
                    end else begin
                        phase_next = lz2f_pkg::PH_COPY;
                        if (phase_reg == lz2f_pkg::PH_SM_LO) begin
                            rem_next = CW'(b[4:0]) + lz2f_pkg::SM_LEN_BIAS;
                        end else begin
                            rem_next = CW'({partial_reg, b[4:0]}) + lz2f_pkg::LM_LEN_BIAS;
                        end
                    end
                end
                lz2f_pkg::PH_SUB:
                begin
                    partial_next = b[5:0];
                    case (b[7:6])
                        lz2f_pkg::SUB_LONG_LIT:   phase_next = lz2f_pkg::PH_LL_LO;
                        lz2f_pkg::SUB_LONG_MATCH: phase_next = lz2f_pkg::PH_LM_HI;
                        lz2f_pkg::SUB_NOP:        adv_code   = 1'b1;
                        default:
                        begin
                            // skip n bytes; a skip of zero ends the group at once
                            rem_next = CW'(b[5:0]);
                            if (b[5:0] == 6'd0) begin
                                close_group = 1'b1;
                            end else begin
                                phase_next = lz2f_pkg::PH_SKIP;
                            end
                        end
                    endcase
                end
                lz2f_pkg::PH_LL_LO:
                begin
                    rem_next   = CW'({partial_reg, b}) + lz2f_pkg::LL_BIAS;
                    phase_next = lz2f_pkg::PH_LIT;
                end
                lz2f_pkg::PH_SKIP:
                begin
                    rem_next = rem_reg - CW'(1);
                    if (rem_reg == CW'(1)) begin
                        close_group = 1'b1;
                    end
                end
                default:
                begin
                    // byte while a match is pending: hold the match
                    err = lz2f_pkg::ERR_ORDER;
                end
            endcase
        end

        // move on to the next code of the flag group
        if (adv_code) begin
            slot_next  = slot_inc;
            flags_next = flags_shift;
            if (slot_inc >= lz2f_pkg::GROUP_SLOTS) begin
                close_group = 1'b1;
            end else begin
                phase_next = lz2f_pkg::code_phase(flags_shift[1:0]);
                if (flags_shift[1:0] == lz2f_pkg::CODE_LIT) begin
                    rem_next = CW'(1);
                end
            end
        end
        if (close_group) begin
            slot_next  = lz2f_pkg::GROUP_SLOTS;
            phase_next = lz2f_pkg::PH_FLAG;
        end

        if (emit) begin
            produced_next = produced_inc;
            hp_next       = (hp_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : hp_reg + AW'(1);
        end
        last = emit && (produced_inc == orig_len_reg);
        pend = !done && (phase_next == lz2f_pkg::PH_COPY) && !last;
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg    <= lz2f_pkg::PH_FLAG;
            flags_reg    <= '0;
            slot_reg     <= lz2f_pkg::GROUP_SLOTS;
            rem_reg      <= '0;
            dist_reg     <= '0;
            partial_reg  <= '0;
            produced_reg <= '0;
            orig_len_reg <= '0;
            hp_reg       <= '0;
        end else if (cfg_we) begin
            // new stream: clear the parser, keep history and its pointer
            orig_len_reg <= cfg_wdata;
            phase_reg    <= lz2f_pkg::PH_FLAG;
            flags_reg    <= '0;
            slot_reg     <= lz2f_pkg::GROUP_SLOTS;
            rem_reg      <= '0;
            dist_reg     <= '0;
            partial_reg  <= '0;
            produced_reg <= '0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            flags_reg    <= flags_next;
            slot_reg     <= slot_next;
            rem_reg      <= rem_next;
            dist_reg     <= dist_next;
            partial_reg  <= partial_next;
            produced_reg <= produced_next;
            hp_reg       <= hp_next;
        end
    end

    // Valid flags of stage 1 and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // History RAM: read at accept, write back from stage 1
    // ---------------------------------------------------------------
    assign s1_byte = !s1_from_mem_reg ? s1_lit_reg :
                     (s1_fwd_reg ? fwd_byte_reg : hist_rdata_reg);

    always_ff @(posedge clk)
    begin
        if (accept) begin
            hist_rdata_reg <= hist_mem[raddr];
        end
        if (s1_valid_reg && s1_emit_reg) begin
            hist_mem[s1_waddr_reg] <= s1_byte;
        end
    end

    // Stage 1 and output payload
    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_emit_reg     <= emit;
            s1_from_mem_reg <= from_mem;
            // the RAM still holds the old byte if stage 1 writes this address now
            s1_fwd_reg      <= s1_valid_reg && s1_emit_reg && (raddr == s1_waddr_reg);
            fwd_byte_reg    <= s1_byte;
            s1_lit_reg      <= b;
            s1_waddr_reg    <= hp_reg;
            s1_last_reg     <= last;
            s1_pend_reg     <= pend;
            s1_err_reg      <= err;
        end
        if (s1_adv) begin
            out_emit_reg <= s1_emit_reg;
            out_byte_reg <= s1_emit_reg ? s1_byte : 8'd0;
            out_pend_reg <= s1_pend_reg;
            out_last_reg <= s1_last_reg;
            out_err_reg  <= s1_err_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_pend_reg, out_byte_reg};
    assign m_axis_tuser  = {out_err_reg, out_emit_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule
